// ===== hdl/mplh_pkg.sv =====
// ----------------------------------------------------------------------------
// mplh_pkg: shared definitions for the memory pressure level block
// Widths, digit sizes, register indexes, level codes and state types.
// ----------------------------------------------------------------------------
package mplh_pkg;

	// page counter width and derived widths
	localparam int COUNT_WIDTH = 32;
	localparam int USED_W      = COUNT_WIDTH + 1;
	localparam int DIGIT_W     = 4;
	// serial word: room for a sum of three counters, rounded up to whole digits
	localparam int EXT_W       = ((COUNT_WIDTH + 2 + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int NDIG        = EXT_W / DIGIT_W;
	localparam int DIG_CW      = $clog2(NDIG);

	// percentage
	localparam int PCT_SCALE = 100;
	localparam int PCT_W     = 8;
	localparam int PROD_W    = USED_W + $clog2(PCT_SCALE);
	localparam int PCT_CW    = $clog2(PCT_W);

	// levels
	localparam int LEVEL_COUNT = 5;
	localparam int LVL_W       = 3;
	localparam logic [LVL_W-1:0] LVL_NORMAL   = 3'd0;
	localparam logic [LVL_W-1:0] LVL_MEDIUM   = 3'd1;
	localparam logic [LVL_W-1:0] LVL_LOW      = 3'd2;
	localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd3;
	localparam logic [LVL_W-1:0] LVL_REBOOT   = 3'd4;

	// threshold registers
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int THR_W     = 8;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_MEDIUM   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_LOW      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_CRITICAL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_REBOOT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LEAVE_MEDIUM   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LEAVE_LOW      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LEAVE_CRITICAL = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_LEAVE_REBOOT   = 3'd7;

	localparam logic [THR_W-1:0] THR_RESET [REG_COUNT] = '{
		8'd90, 8'd100, 8'd114, 8'd120, 8'd84, 8'd94, 8'd108, 8'd112
	};

	// status of a multi-cycle unit
	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	// passes of the digit-serial arithmetic
	typedef enum logic [1:0] {
		PS_DIFF,
		PS_AVAIL,
		PS_RAMSUB,
		PS_USED
	} pass_t;

	// top-level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARITH,
		ST_DIV,
		ST_DONE
	} top_st_t;

endpackage

// ===== hdl/mplh_serial.sv =====
// ----------------------------------------------------------------------------
// mplh_serial: digit-serial page arithmetic
// Forms used pages from the counter sample in four passes over 4-bit digits,
// least significant digit first, with saturating subtractions.
// ----------------------------------------------------------------------------
module mplh_serial (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] file_cache_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] shared_mem_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] slab_reclaim_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] free_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] reserved_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] ram_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] swap_total_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] swap_free_pages,
	output logic [mplh_pkg::USED_W-1:0]      used,
	output logic [mplh_pkg::COUNT_WIDTH-1:0] ram,
	output mplh_pkg::eng_stat_t              stat
);
	import mplh_pkg::*;

	// operand shift registers, rotated one digit per cycle while the unit is busy
	logic [EXT_W-1:0] fc_q, sh_q, slab_q, fr_q, rs_q, ram_q, swt_q, swf_q;
	logic [EXT_W-1:0] fc_n, fr_n, swt_n;
	logic [1:0]        cy_q;
	logic [2:0]        bw_q;
	logic [DIG_CW-1:0] dig_q;
	pass_t             pass_q, pass_n;
	logic              busy_q, done_q;

	logic              first, last;
	logic [1:0]        cy_in;
	logic [2:0]        bw_in;
	logic [DIGIT_W-1:0] sa_x, sa_y, add_x, add_y, add_z;
	logic [DIGIT_W:0]   sub_a, sub_b, sub_c;
	logic [DIGIT_W+1:0] add_s;

	function automatic logic [EXT_W-1:0] rot_digit(input logic [EXT_W-1:0] v);
		return {v[DIGIT_W-1:0], v[EXT_W-1:DIGIT_W]};
	endfunction

	assign first = (dig_q == '0);
	assign last  = (dig_q == DIG_CW'(NDIG - 1));
	assign cy_in = first ? 2'b00 : cy_q;
	assign bw_in = first ? 3'b000 : bw_q;

	// operand selection per pass
	always_comb begin
		sa_x  = (pass_q == PS_RAMSUB) ? ram_q[DIGIT_W-1:0] : fc_q[DIGIT_W-1:0];
		sa_y  = (pass_q == PS_RAMSUB) ? fc_q[DIGIT_W-1:0]  : sh_q[DIGIT_W-1:0];
		add_x = (pass_q == PS_USED)   ? fr_q[DIGIT_W-1:0]  : fc_q[DIGIT_W-1:0];
		add_y = (pass_q == PS_USED)   ? swt_q[DIGIT_W-1:0] : slab_q[DIGIT_W-1:0];
		add_z = (pass_q == PS_USED)   ? '0                 : fr_q[DIGIT_W-1:0];
	end

	// one digit of each serial subtractor and of the three-input adder
	assign sub_a = {1'b0, sa_x} - {1'b0, sa_y} - (DIGIT_W+1)'(bw_in[0]);
	assign sub_b = {1'b0, fr_q[DIGIT_W-1:0]} - {1'b0, rs_q[DIGIT_W-1:0]}
		- (DIGIT_W+1)'(bw_in[1]);
	assign sub_c = {1'b0, swt_q[DIGIT_W-1:0]} - {1'b0, swf_q[DIGIT_W-1:0]}
		- (DIGIT_W+1)'(bw_in[2]);
	assign add_s = (DIGIT_W+2)'(add_x) + (DIGIT_W+2)'(add_y) + (DIGIT_W+2)'(add_z)
		+ (DIGIT_W+2)'(cy_in);

	// result digits enter at the top; a final borrow clears the word
	always_comb begin
		fc_n  = rot_digit(fc_q);
		fr_n  = rot_digit(fr_q);
		swt_n = rot_digit(swt_q);
		unique case (pass_q)
			PS_DIFF: begin
				fc_n  = {sub_a[DIGIT_W-1:0], fc_q[EXT_W-1:DIGIT_W]};
				fr_n  = {sub_b[DIGIT_W-1:0], fr_q[EXT_W-1:DIGIT_W]};
				swt_n = {sub_c[DIGIT_W-1:0], swt_q[EXT_W-1:DIGIT_W]};
				if (last && sub_a[DIGIT_W]) begin
					fc_n = '0;
				end
				if (last && sub_b[DIGIT_W]) begin
					fr_n = '0;
				end
				if (last && sub_c[DIGIT_W]) begin
					swt_n = '0;
				end
			end
			PS_AVAIL: begin
				fc_n = {add_s[DIGIT_W-1:0], fc_q[EXT_W-1:DIGIT_W]};
			end
			PS_RAMSUB: begin
				fr_n = {sub_a[DIGIT_W-1:0], fr_q[EXT_W-1:DIGIT_W]};
				if (last && sub_a[DIGIT_W]) begin
					fr_n = '0;
				end
			end
			PS_USED: begin
				fr_n = {add_s[DIGIT_W-1:0], fr_q[EXT_W-1:DIGIT_W]};
			end
			default: begin
				fc_n = rot_digit(fc_q);
			end
		endcase
	end

	// pass order
	always_comb begin
		unique case (pass_q)
			PS_DIFF:   pass_n = PS_AVAIL;
			PS_AVAIL:  pass_n = PS_RAMSUB;
			PS_RAMSUB: pass_n = PS_USED;
			PS_USED:   pass_n = PS_DIFF;
			default:   pass_n = PS_DIFF;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pass_q <= PS_DIFF;
			dig_q  <= '0;
		end else begin
			done_q <= busy_q && last && (pass_q == PS_USED);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				pass_q <= PS_DIFF;
				dig_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					dig_q  <= '0;
					pass_q <= pass_n;
					if (pass_q == PS_USED) begin
						busy_q <= 1'b0;
					end
				end else begin
					dig_q <= dig_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			fc_q   <= EXT_W'(file_cache_pages);
			sh_q   <= EXT_W'(shared_mem_pages);
			slab_q <= EXT_W'(slab_reclaim_pages);
			fr_q   <= EXT_W'(free_pages);
			rs_q   <= EXT_W'(reserved_pages);
			ram_q  <= EXT_W'(ram_pages);
			swt_q  <= EXT_W'(swap_total_pages);
			swf_q  <= EXT_W'(swap_free_pages);
		end else if (busy_q) begin
			fc_q   <= fc_n;
			sh_q   <= rot_digit(sh_q);
			slab_q <= rot_digit(slab_q);
			fr_q   <= fr_n;
			rs_q   <= rot_digit(rs_q);
			ram_q  <= rot_digit(ram_q);
			swt_q  <= swt_n;
			swf_q  <= rot_digit(swf_q);
			cy_q   <= add_s[DIGIT_W+1:DIGIT_W];
			bw_q   <= {sub_c[DIGIT_W], sub_b[DIGIT_W], sub_a[DIGIT_W]};
		end
	end

	assign used      = fr_q[USED_W-1:0];
	assign ram       = ram_q[COUNT_WIDTH-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/mplh_div.sv =====
// ----------------------------------------------------------------------------
// mplh_div: used percentage divider
// Scales used pages by 100, checks for a quotient above 255, then produces
// the eight quotient bits by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module mplh_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mplh_pkg::USED_W-1:0]      used,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0] ram,
	output logic [mplh_pkg::PCT_W-1:0]       pct,
	output mplh_pkg::eng_stat_t              stat
);
	import mplh_pkg::*;

	logic [PROD_W-1:0]      prod_q;
	logic [COUNT_WIDTH-1:0] ram_q, rem_q;
	logic [PCT_W-1:0]       lo_q, quot_q;
	logic                   sat_q, run_q, cmp_q, done_q;
	logic [PCT_CW-1:0]      cnt_q;

	logic [COUNT_WIDTH+1:0] trial;
	logic                   ge;

	// trial subtraction of the divisor
	assign trial = {1'b0, rem_q, lo_q[PCT_W-1]} - {2'b00, ram_q};
	assign ge    = !trial[COUNT_WIDTH+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cmp_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q) begin
				run_q <= 1'b1;
				cmp_q <= 1'b1;
			end else if (run_q && cmp_q) begin
				cmp_q <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == PCT_CW'(PCT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; zero RAM pages also reads as saturated
	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			prod_q <= PROD_W'(used) * PROD_W'(PCT_SCALE);
			ram_q  <= ram;
		end else if (run_q && cmp_q) begin
			rem_q  <= prod_q[PROD_W-1:PCT_W];
			lo_q   <= prod_q[PCT_W-1:0];
			sat_q  <= (prod_q[PROD_W-1:PCT_W] >= ram_q);
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? trial[COUNT_WIDTH-1:0]
				: {rem_q[COUNT_WIDTH-2:0], lo_q[PCT_W-1]};
			lo_q   <= {lo_q[PCT_W-2:0], 1'b0};
			quot_q <= {quot_q[PCT_W-2:0], ge};
		end
	end

	assign pct       = sat_q ? '1 : quot_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/memory_pressure_level_hysteresis.sv =====
// ----------------------------------------------------------------------------
// memory_pressure_level_hysteresis: pressure level from page counters
// Used pages are reported, and their percentage of RAM selects one of five levels, with a
// separate leave threshold per level for hysteresis.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+------------------------------
//  in      | in_valid/in_ready, 8 page counts | in_valid & in_ready
//  out     | out_valid/out_ready, 4 fields    | out_valid & out_ready
//  cfg     | cfg_wr_en, cfg_addr, cfg_wr_data | cfg_wr_en (no stall)
//
//  out_valid rises after the input transfer once the digit-serial page arithmetic
//  (4 passes of 9 four-bit digits), the divider (scale, range check, 8 quotient
//  bits), the hand-over and the commit have run, in that order.
//  One item is in work at a time, so a new item is taken only once the last one
//  is committed; the next one is taken while a result waits.
//  A stalled result holds the engine only at commit. Reset sets the held level normal.
// ----------------------------------------------------------------------------
module memory_pressure_level_hysteresis (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [mplh_pkg::REG_IDX_W-1:0]      cfg_addr,
	input  logic [mplh_pkg::THR_W-1:0]          cfg_wr_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     file_cache_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     shared_mem_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     slab_reclaim_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     free_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     reserved_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     ram_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     swap_total_pages,
	input  logic [mplh_pkg::COUNT_WIDTH-1:0]     swap_free_pages,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mplh_pkg::LVL_W-1:0]          level,
	output logic [mplh_pkg::USED_W-1:0]         used_pages,
	output logic [mplh_pkg::PCT_W-1:0]          used_percent,
	output logic                                level_changed
);
	import mplh_pkg::*;

	top_st_t           st_q, st_n;
	logic [THR_W-1:0]  thr_q [REG_COUNT];
	logic [LVL_W-1:0]  held_q, level_q;
	logic [USED_W-1:0] used_q;
	logic [PCT_W-1:0]  pct_q;
	logic              chg_q, out_valid_q;

	logic              ser_start, div_start, commit;
	eng_stat_t         ser_stat, div_stat;
	logic [USED_W-1:0]      ser_used;
	logic [COUNT_WIDTH-1:0] ser_ram;
	logic [PCT_W-1:0]       div_pct;
	logic [LVL_W-1:0]       lvl_new;
	logic [REG_IDX_W-1:0]   leave_idx;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q[cfg_addr] <= cfg_wr_data;
		end
	end

	// sequencer: next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_valid) st_n = ST_ARITH;
			ST_ARITH: if (ser_stat.done) st_n = ST_DIV;
			ST_DIV:   if (div_stat.done) st_n = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) st_n = ST_IDLE;
			default:  st_n = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready  = (st_q == ST_IDLE);
		ser_start = (st_q == ST_IDLE) && in_valid;
		div_start = (st_q == ST_ARITH) && ser_stat.done;
		commit    = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	mplh_serial u_serial (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (ser_start),
		.file_cache_pages   (file_cache_pages),
		.shared_mem_pages   (shared_mem_pages),
		.slab_reclaim_pages (slab_reclaim_pages),
		.free_pages         (free_pages),
		.reserved_pages     (reserved_pages),
		.ram_pages          (ram_pages),
		.swap_total_pages   (swap_total_pages),
		.swap_free_pages    (swap_free_pages),
		.used               (ser_used),
		.ram                (ser_ram),
		.stat               (ser_stat)
	);

	mplh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.used   (ser_used),
		.ram    (ser_ram),
		.pct    (div_pct),
		.stat   (div_stat)
	);

	// level pick: highest enter threshold exceeded, then hold on hysteresis
	assign leave_idx = held_q + REG_IDX_W'(REG_LEAVE_MEDIUM - 1);

	always_comb begin
		lvl_new = LVL_NORMAL;
		for (int i = 1; i < LEVEL_COUNT; i++) begin
			if (div_pct > thr_q[i-1]) begin
				lvl_new = LVL_W'(i);
			end
		end
		if ((lvl_new < held_q) && (held_q != LVL_NORMAL)
			&& (div_pct > thr_q[leave_idx])) begin
			lvl_new = held_q;
		end
	end

	// result register and held level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= LVL_NORMAL;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				held_q      <= lvl_new;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			level_q <= lvl_new;
			used_q  <= ser_used;
			pct_q   <= div_pct;
			chg_q   <= (lvl_new != held_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign used_pages    = used_q;
	assign used_percent  = pct_q;
	assign level_changed = chg_q;

	// checks
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ser_stat.busy && div_stat.busy))
		else $error("serial unit and divider busy together");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ser_stat.busy)
		else $error("accepted item did not start the serial unit");

	a_commit_held: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (out_valid && (held_q == level)))
		else $error("held level differs from the level just delivered");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: memory pressure level block with hysteresis
// Drives page counter samples over the valid/ready input channel, predicts
// level, used pages, used percent and the changed flag for each transfer,
// and checks every result in order. Covers the counter extremes, the
// saturating differences, zero RAM, percent saturation, enter and leave
// hysteresis, and many threshold settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import mplh_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 60;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 130;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] file_cache;
		logic [COUNT_WIDTH-1:0] shared_mem;
		logic [COUNT_WIDTH-1:0] slab_reclaim;
		logic [COUNT_WIDTH-1:0] free_cnt;
		logic [COUNT_WIDTH-1:0] reserved;
		logic [COUNT_WIDTH-1:0] ram;
		logic [COUNT_WIDTH-1:0] swap_total;
		logic [COUNT_WIDTH-1:0] swap_free;
	} sample_t;

	typedef struct packed {
		logic [LVL_W-1:0]  level;
		logic [USED_W-1:0] used;
		logic [PCT_W-1:0]  pct;
		logic              changed;
	} report_t;

	typedef logic [THR_W-1:0] thr_set_t [REG_COUNT];

	logic clk;
	logic arst_n = 1'b0;

	logic                 cfg_wr_en   = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr    = '0;
	logic [THR_W-1:0]     cfg_wr_data = '0;

	logic    in_valid   = 1'b0;
	logic    in_ready;
	sample_t cur_sample = '0;

	logic [COUNT_WIDTH-1:0] file_cache_pages;
	logic [COUNT_WIDTH-1:0] shared_mem_pages;
	logic [COUNT_WIDTH-1:0] slab_reclaim_pages;
	logic [COUNT_WIDTH-1:0] free_pages;
	logic [COUNT_WIDTH-1:0] reserved_pages;
	logic [COUNT_WIDTH-1:0] ram_pages;
	logic [COUNT_WIDTH-1:0] swap_total_pages;
	logic [COUNT_WIDTH-1:0] swap_free_pages;

	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [LVL_W-1:0]  level;
	logic [USED_W-1:0] used_pages;
	logic [PCT_W-1:0]  used_percent;
	logic              level_changed;

	// predictor state
	logic [THR_W-1:0] thr_model [REG_COUNT];
	logic [LVL_W-1:0] held_model;
	report_t          level_reports_q [$];

	// run bookkeeping
	bit                   idle_off = 1'b0;
	int unsigned          cycle_count = 0;
	int unsigned          fail_count = 0;
	int unsigned          sent_count = 0;
	int unsigned          checked_count = 0;
	int unsigned          change_count = 0;
	int unsigned          setting_count = 0;
	logic [LEVEL_COUNT-1:0] levels_seen = '0;

	assign file_cache_pages   = cur_sample.file_cache;
	assign shared_mem_pages   = cur_sample.shared_mem;
	assign slab_reclaim_pages = cur_sample.slab_reclaim;
	assign free_pages         = cur_sample.free_cnt;
	assign reserved_pages     = cur_sample.reserved;
	assign ram_pages          = cur_sample.ram;
	assign swap_total_pages   = cur_sample.swap_total;
	assign swap_free_pages    = cur_sample.swap_free;

	memory_pressure_level_hysteresis dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_addr           (cfg_addr),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.file_cache_pages   (file_cache_pages),
		.shared_mem_pages   (shared_mem_pages),
		.slab_reclaim_pages (slab_reclaim_pages),
		.free_pages         (free_pages),
		.reserved_pages     (reserved_pages),
		.ram_pages          (ram_pages),
		.swap_total_pages   (swap_total_pages),
		.swap_free_pages    (swap_free_pages),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level              (level),
		.used_pages         (used_pages),
		.used_percent       (used_percent),
		.level_changed      (level_changed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d results outstanding", $time, level_reports_q.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit idle_now();
		return !idle_off && ($urandom_range(99) < 9);
	endfunction

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------
	function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [THR_W-1:0] enter_thr(input logic [LVL_W-1:0] lv);
		case (lv)
			LVL_MEDIUM:   return thr_model[REG_ENTER_MEDIUM];
			LVL_LOW:      return thr_model[REG_ENTER_LOW];
			LVL_CRITICAL: return thr_model[REG_ENTER_CRITICAL];
			default:      return thr_model[REG_ENTER_REBOOT];
		endcase
	endfunction

	function automatic logic [THR_W-1:0] leave_thr(input logic [LVL_W-1:0] lv);
		case (lv)
			LVL_MEDIUM:   return thr_model[REG_LEAVE_MEDIUM];
			LVL_LOW:      return thr_model[REG_LEAVE_LOW];
			LVL_CRITICAL: return thr_model[REG_LEAVE_CRITICAL];
			default:      return thr_model[REG_LEAVE_REBOOT];
		endcase
	endfunction

	// computes one report and advances the held level
	function automatic report_t predict_pressure(input sample_t s);
		logic [63:0]      avail;
		logic [63:0]      used;
		logic [63:0]      quot;
		logic [PCT_W-1:0] pct;
		logic [LVL_W-1:0] lv;
		report_t          r;
		avail = floor_sub(64'(s.file_cache), 64'(s.shared_mem)) + 64'(s.slab_reclaim)
			+ floor_sub(64'(s.free_cnt), 64'(s.reserved));
		used = floor_sub(64'(s.ram), avail) + floor_sub(64'(s.swap_total), 64'(s.swap_free));
		if (s.ram == '0) begin
			pct = '1;
		end else begin
			quot = (used * PCT_SCALE) / 64'(s.ram);
			pct = (quot > 64'd255) ? 8'd255 : quot[PCT_W-1:0];
		end
		// highest level whose enter threshold is exceeded, reboot first
		if (pct > enter_thr(LVL_REBOOT))        lv = LVL_REBOOT;
		else if (pct > enter_thr(LVL_CRITICAL)) lv = LVL_CRITICAL;
		else if (pct > enter_thr(LVL_LOW))      lv = LVL_LOW;
		else if (pct > enter_thr(LVL_MEDIUM))   lv = LVL_MEDIUM;
		else                                    lv = LVL_NORMAL;
		// hysteresis: keep the held level until at or below its leave threshold
		if (lv < held_model && held_model != LVL_NORMAL && pct > leave_thr(held_model))
			lv = held_model;
		r.level   = lv;
		r.used    = used[USED_W-1:0];
		r.pct     = pct;
		r.changed = (lv != held_model);
		held_model = lv;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// sample builders
	// ---------------------------------------------------------------------
	// sample with the given RAM size at about p percent used, content split at random
	function automatic sample_t build_sample(input logic [31:0] ram, input int unsigned p);
		sample_t     s;
		logic [63:0] u, m, sw, a, r, fr, fc, part;
		u  = (64'(p) * 64'(ram)) / 100;
		m  = (u > 64'(ram)) ? 64'(ram) : u;
		sw = u - m;
		if (u <= 64'(ram) && $urandom_range(1)) begin
			part = 64'($urandom_range(m[31:0], 0));
			m    = m - part;
			sw   = sw + part;
		end
		a  = 64'(ram) - m;
		s.ram          = ram;
		s.slab_reclaim = $urandom_range(a[31:0], 0);
		r  = a - 64'(s.slab_reclaim);
		fr = 64'($urandom_range(r[31:0], 0));
		fc = r - fr;
		s.shared_mem = $urandom_range(~fc[31:0], 0);
		s.file_cache = fc[31:0] + s.shared_mem;
		s.reserved   = $urandom_range(~fr[31:0], 0);
		s.free_cnt   = fr[31:0] + s.reserved;
		s.swap_free  = $urandom_range(~sw[31:0], 0);
		s.swap_total = sw[31:0] + s.swap_free;
		return s;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] noise_count();
		case ($urandom_range(3))
			0:       return '0;
			1:       return $urandom;
			2:       return $urandom_range(4095);
			default: return ~$urandom_range(4095);
		endcase
	endfunction

	function automatic sample_t noise_sample();
		sample_t s;
		s.file_cache   = noise_count();
		s.shared_mem   = noise_count();
		s.slab_reclaim = noise_count();
		s.free_cnt     = noise_count();
		s.reserved     = noise_count();
		s.ram          = noise_count();
		s.swap_total   = noise_count();
		s.swap_free    = noise_count();
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------------
	// one sample transfer; valid stays high on return until the next falling edge
	task automatic send_sample(input sample_t s);
		@(negedge clk);
		while (idle_now()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cur_sample = s;
		in_valid   = 1'b1;
		do @(posedge clk); while (!in_ready);
		level_reports_q.push_back(predict_pressure(s));
		sent_count++;
	endtask

	// sender pauses until every expected report has come, then the block settles
	task automatic wait_idle(input int unsigned settle);
		@(negedge clk);
		in_valid = 1'b0;
		while (level_reports_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// writes all eight thresholds; only called while the block is idle
	task automatic write_thresholds(input thr_set_t t);
		for (int i = 0; i < REG_COUNT; i++) begin
			@(negedge clk);
			cfg_wr_en   = 1'b1;
			cfg_addr    = i[REG_IDX_W-1:0];
			cfg_wr_data = t[i];
			thr_model[i] = t[i];
		end
		@(negedge clk);
		cfg_wr_en = 1'b0;
		setting_count++;
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready = arst_n && !idle_now();
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (level_reports_q.size() == 0) begin
				$display("%0t: unexpected result: level %0d used %0d pct %0d changed %0b",
					$time, level, used_pages, used_percent, level_changed);
				fail_count++;
			end else begin
				exp_r = level_reports_q.pop_front();
				checked_count++;
				if (level !== exp_r.level) begin
					$display("%0t: level mismatch: expected %0d, got %0d",
						$time, exp_r.level, level);
					fail_count++;
				end
				if (used_pages !== exp_r.used) begin
					$display("%0t: used_pages mismatch: expected %0d, got %0d",
						$time, exp_r.used, used_pages);
					fail_count++;
				end
				if (used_percent !== exp_r.pct) begin
					$display("%0t: used_percent mismatch: expected %0d, got %0d",
						$time, exp_r.pct, used_percent);
					fail_count++;
				end
				if (level_changed !== exp_r.changed) begin
					$display("%0t: level_changed mismatch: expected %0b, got %0b",
						$time, exp_r.changed, level_changed);
					fail_count++;
				end
				if (exp_r.changed)
					change_count++;
				if (exp_r.level < LEVEL_COUNT)
					levels_seen[exp_r.level] = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------
	// reset thresholds: climb through every level, hold and fall on the leave thresholds, then counter extremes
	task automatic test_reset_hysteresis();
		sample_t s;
		int unsigned walk [12] = '{50, 91, 85, 84, 101, 95, 94, 115, 121, 113, 112, 0};
		foreach (walk[i])
			send_sample(build_sample(32'd1000, walk[i]));
		// percent far above 100
		send_sample(build_sample(32'd100, 255));
		// everything zero: zero RAM
		s = '0;
		send_sample(s);
		// everything at maximum
		s = '1;
		send_sample(s);
		// largest used count
		s = '0;
		s.ram        = '1;
		s.swap_total = '1;
		send_sample(s);
		// shared above cache and reserved above free both floor at zero
		s = '0;
		s.file_cache = 32'd5;
		s.shared_mem = 32'd9;
		s.free_cnt   = 32'd3;
		s.reserved   = 32'd7;
		s.ram        = 32'd10;
		send_sample(s);
		// reclaimable above RAM, swap free above swap total
		s = '0;
		s.slab_reclaim = 32'd2000;
		s.ram          = 32'd1000;
		s.swap_total   = 32'd4;
		s.swap_free    = 32'd40;
		send_sample(s);
		// tiny RAM, quotient above 255
		s = '0;
		s.ram        = 32'd1;
		s.swap_total = 32'd7;
		send_sample(s);
		wait_idle(SETTLE_CYCLES);
	endtask

	// all-zero, all-max and reversed threshold sets
	task automatic test_threshold_extremes();
		thr_set_t t;
		foreach (t[i]) t[i] = '0;
		write_thresholds(t);
		send_sample(build_sample(32'd1000, 1));
		send_sample(build_sample(32'd1000, 0));
		wait_idle(SETTLE_CYCLES);
		foreach (t[i]) t[i] = '1;
		write_thresholds(t);
		send_sample(build_sample(32'd100, 255));
		wait_idle(SETTLE_CYCLES);
		// enter thresholds falling with level: reboot test wins first
		t = '{8'd200, 8'd150, 8'd100, 8'd50, 8'd0, 8'd255, 8'd30, 8'd40};
		write_thresholds(t);
		send_sample(build_sample(32'd1000, 60));
		send_sample(build_sample(32'd1000, 45));
		send_sample(build_sample(32'd1000, 20));
		wait_idle(SETTLE_CYCLES);
	endtask

	function automatic thr_set_t random_thresholds(input int unsigned kind);
		thr_set_t    t;
		int unsigned base;
		case (kind % 4)
			0: begin
				// ordered enters; medium leave anywhere from its enter down to zero, other leaves a little below their enters
				base = $urandom_range(160);
				t[REG_ENTER_MEDIUM]   = THR_W'(base);
				t[REG_ENTER_LOW]      = THR_W'(base + $urandom_range(30));
				t[REG_ENTER_CRITICAL] = THR_W'(t[REG_ENTER_LOW] + $urandom_range(30));
				t[REG_ENTER_REBOOT]   = THR_W'(t[REG_ENTER_CRITICAL] + $urandom_range(30));
				t[REG_LEAVE_MEDIUM]   = THR_W'(t[REG_ENTER_MEDIUM]
					- $urandom_range(t[REG_ENTER_MEDIUM]));
				t[REG_LEAVE_LOW]      = THR_W'(t[REG_ENTER_LOW] - $urandom_range(12));
				t[REG_LEAVE_CRITICAL] = THR_W'(t[REG_ENTER_CRITICAL] - $urandom_range(12));
				t[REG_LEAVE_REBOOT]   = THR_W'(t[REG_ENTER_REBOOT] - $urandom_range(12));
			end
			1: foreach (t[i]) t[i] = THR_W'($urandom_range(255));
			2: begin
				// tight cluster so levels flip often
				base = $urandom_range(40, 200);
				foreach (t[i]) t[i] = THR_W'(base - 10 + $urandom_range(20));
			end
			default: begin
				foreach (t[i]) begin
					case ($urandom_range(2))
						0:       t[i] = '0;
						1:       t[i] = '1;
						default: t[i] = THR_W'($urandom_range(255));
					endcase
				end
			end
		endcase
		return t;
	endfunction

	// random walks of the used percent, plus noise and zero-RAM samples
	task automatic test_random_phases();
		int          pct_walk;
		int unsigned pick;
		logic [31:0] ram;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			// first phase runs with no stalls on either side
			idle_off = (ph == 0);
			write_thresholds(random_thresholds(ph));
			pct_walk = $urandom_range(255);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					send_sample(noise_sample());
				end else if (pick < 13) begin
					send_sample(build_sample(32'd0, $urandom_range(255)));
				end else begin
					if ($urandom_range(19) == 0)
						pct_walk = $urandom_range(255);
					else
						pct_walk = pct_walk + $urandom_range(16) - 8;
					if (pct_walk < 0)   pct_walk = 0;
					if (pct_walk > 255) pct_walk = 255;
					case ($urandom_range(2))
						0:       ram = 32'd100;
						1:       ram = 32'd1000;
						default: ram = $urandom_range(32'h4000_0000, 1);
					endcase
					send_sample(build_sample(ram, pct_walk));
				end
			end
			wait_idle(SETTLE_CYCLES);
		end
		idle_off = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------
	initial begin
		foreach (thr_model[i]) thr_model[i] = THR_RESET[i];
		held_model = LVL_NORMAL;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_hysteresis();
		test_threshold_extremes();
		test_random_phases();

		wait_idle(DRAIN_CYCLES);
		if (level_reports_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, level_reports_q.size());
			fail_count++;
		end
		$display("Sent %0d samples, checked %0d results with %0d level changes",
			sent_count, checked_count, change_count);
		$display("Threshold sets written: %0d, levels reached (bit per level): %b",
			setting_count, levels_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
